@@ hw/rtl/tpps_pkg.sv @@
`default_nettype none
package tpps_pkg;

  localparam int WAIT_WIDTH = 16;
  localparam logic [31:0] WAIT_MAX = 32'((64'd1 << WAIT_WIDTH) - 64'd1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BURST_REPEATS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HALF_TICKS = 1'd1;

  localparam logic [7:0] BURST_REPEATS_RST    = 8'd3;
  localparam logic [15:0] PULSE_HALF_TICKS_RST = 16'd20000;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_PULSE = 2'd1;
  localparam logic [1:0] MODE_PHASE = 2'd2;

  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_2    = 8'h32;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LZ   = 8'h7a;
  localparam logic [7:0] CH_UB   = 8'h42;
  localparam logic [7:0] CH_UZ   = 8'h5a;
  localparam logic [7:0] NO_PREFIX = 8'd0;

  localparam logic [7:0] DELAY_BASE     = 8'd200;
  localparam logic [7:0] DELAY_FALLBACK = 8'd75;
  localparam logic [7:0] LOWER_BASE_IDX = 8'd10;
  localparam logic [7:0] UPPER_BASE_IDX = 8'd36;

  localparam logic [2:0] LAMP_IDLE    = 3'b001;
  localparam logic [2:0] LAMP_PULSE   = 3'b010;
  localparam logic [2:0] LAMP_PHASE   = 3'b100;
  localparam logic [2:0] LAMP_UNKNOWN = 3'b101;

  localparam logic [2:0] STEPS_PER_CYCLE = 3'd6;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic phase_a;
    logic phase_b;
    logic phase_c;
    logic lamp_idle;
    logic lamp_pulse;
    logic lamp_phase;
    logic pulse_out;
    logic reply_valid;
    logic reply_is_error;
  } out_t;

  typedef struct packed {
    logic [7:0] requested_mode;
    logic [7:0] step_delay;
  } cmd_state_t;

  typedef struct packed {
    logic [7:0]  burst_repeats;
    logic [15:0] pulse_half_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] lamp;
    logic       pulse;
  } pins_t;

  typedef struct packed {
    logic valid;
    logic is_error;
  } reply_t;

  function automatic logic [7:0] delay_of_char(input logic [7:0] c);
    logic [7:0] idx;
    logic       hit;
    begin
      idx = 8'd0;
      hit = 1'b1;
      if (c >= CH_0 && c <= CH_9) begin
        idx = c - CH_0;
      end else if (c >= CH_LA && c <= CH_LZ) begin
        idx = LOWER_BASE_IDX + (c - CH_LA);
      end else if (c >= CH_UB && c <= CH_UZ) begin
        idx = UPPER_BASE_IDX + (c - CH_UB);
      end else begin
        hit = 1'b0;
      end
      if (hit) begin
        delay_of_char = DELAY_BASE - 8'((idx << 1) + idx);
      end else begin
        delay_of_char = DELAY_FALLBACK;
      end
    end
  endfunction

  function automatic logic [WAIT_WIDTH-1:0] load_wait(input logic [31:0] d);
    logic [31:0] v;
    begin
      v = (d == 32'd0) ? 32'd1 : d;
      if (v > WAIT_MAX) begin
        v = WAIT_MAX;
      end
      load_wait = WAIT_WIDTH'(v);
    end
  endfunction

  // one step of the six-step pattern: odd steps raise a pin, even steps drop it
  function automatic logic [2:0] step_levels(input logic [2:0] lv, input logic [2:0] s);
    begin
      case (s)
        3'd0:    step_levels = lv & 3'b110;
        3'd1:    step_levels = lv | 3'b010;
        3'd2:    step_levels = lv & 3'b011;
        3'd3:    step_levels = lv | 3'b001;
        3'd4:    step_levels = lv & 3'b101;
        3'd5:    step_levels = lv | 3'b100;
        default: step_levels = lv;
      endcase
    end
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tpps_cmd.sv @@
`default_nettype none
module tpps_cmd (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  byte_en,
  input  wire logic [7:0]            rx_byte,
  output tpps_pkg::cmd_state_t       cmd_state,
  output tpps_pkg::reply_t           reply
);
  import tpps_pkg::*;

  logic [7:0] prefix_r, prefix_nxt;
  logic [7:0] mode_r, mode_nxt;
  logic [7:0] delay_r, delay_nxt;

  always_comb begin
    prefix_nxt     = prefix_r;
    mode_nxt       = mode_r;
    delay_nxt      = delay_r;
    reply.valid    = 1'b0;
    reply.is_error = 1'b0;
    if (byte_en) begin
      if (prefix_r == NO_PREFIX) begin
        prefix_nxt = rx_byte;
      end else begin
        reply.valid = 1'b1;
        if (prefix_r == CH_T) begin
          delay_nxt = delay_of_char(rx_byte);
        end else if (prefix_r == CH_S) begin
          mode_nxt = rx_byte;
        end else begin
          reply.is_error = 1'b1;
        end
        prefix_nxt = NO_PREFIX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= NO_PREFIX;
      mode_r   <= CH_0;
      delay_r  <= 8'd0;
    end else begin
      prefix_r <= prefix_nxt;
      mode_r   <= mode_nxt;
      delay_r  <= delay_nxt;
    end
  end

  assign cmd_state.requested_mode = mode_r;
  assign cmd_state.step_delay     = delay_r;

endmodule
`default_nettype wire

@@ hw/rtl/tpps_seq.sv @@
`default_nettype none
module tpps_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  tick_en,
  input  tpps_pkg::cmd_state_t       cmd_state,
  input  tpps_pkg::cfg_t             cfg,
  output tpps_pkg::pins_t            pins_nxt
);
  import tpps_pkg::*;

  logic [1:0]            mode_r, mode_nxt;
  logic [2:0]            phase_r, phase_nxt;
  logic [2:0]            step_r, step_nxt;
  logic [7:0]            burst_r, burst_nxt;
  logic [WAIT_WIDTH-1:0] wait_r, wait_nxt;
  logic                  pulse_r, pulse_nxt;
  logic [2:0]            lamp_r, lamp_nxt;
  logic                  do_latch;
  logic [2:0]            step_inc;
  logic [7:0]            burst_inc;

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    burst_nxt = burst_r;
    wait_nxt  = wait_r;
    pulse_nxt = pulse_r;
    lamp_nxt  = lamp_r;
    do_latch  = 1'b0;
    step_inc  = step_r + 3'd1;
    burst_inc = burst_r + 8'd1;

    if (tick_en) begin
      if (mode_r != MODE_PULSE && mode_r != MODE_PHASE) begin
        do_latch = 1'b1;
      end else if (wait_r > WAIT_WIDTH'(1)) begin
        wait_nxt = wait_r - WAIT_WIDTH'(1);
      end else if (mode_r == MODE_PULSE) begin
        if (pulse_r) begin
          pulse_nxt = 1'b0;
          wait_nxt  = load_wait(32'(cfg.pulse_half_ticks));
        end else begin
          do_latch = 1'b1;
        end
      end else begin
        if (step_inc >= STEPS_PER_CYCLE) begin
          step_nxt  = 3'd0;
          burst_nxt = burst_inc;
          if (burst_inc >= cfg.burst_repeats) begin
            do_latch = 1'b1;
          end else begin
            phase_nxt = step_levels(phase_r, 3'd0);
            wait_nxt  = load_wait(32'(cmd_state.step_delay));
          end
        end else begin
          step_nxt  = step_inc;
          phase_nxt = step_levels(phase_r, step_inc);
          wait_nxt  = load_wait(32'(cmd_state.step_delay));
        end
      end

      // take the requested mode on this tick
      if (do_latch) begin
        case (cmd_state.requested_mode)
          CH_0: begin
            lamp_nxt = LAMP_IDLE;
            mode_nxt = MODE_IDLE;
          end
          CH_1: begin
            lamp_nxt  = LAMP_PULSE;
            pulse_nxt = 1'b1;
            wait_nxt  = load_wait(32'(cfg.pulse_half_ticks));
            mode_nxt  = MODE_PULSE;
          end
          CH_2: begin
            lamp_nxt = LAMP_PHASE;
            if (cfg.burst_repeats == 8'd0) begin
              mode_nxt = MODE_IDLE;
            end else begin
              burst_nxt = 8'd0;
              step_nxt  = 3'd0;
              phase_nxt = step_levels(phase_r, 3'd0);
              wait_nxt  = load_wait(32'(cmd_state.step_delay));
              mode_nxt  = MODE_PHASE;
            end
          end
          default: begin
            lamp_nxt = LAMP_UNKNOWN;
            mode_nxt = MODE_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      phase_r <= 3'd0;
      step_r  <= 3'd0;
      burst_r <= 8'd0;
      wait_r  <= '0;
      pulse_r <= 1'b0;
      lamp_r  <= LAMP_IDLE;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      burst_r <= burst_nxt;
      wait_r  <= wait_nxt;
      pulse_r <= pulse_nxt;
      lamp_r  <= lamp_nxt;
    end
  end

  assign pins_nxt.phase = phase_nxt;
  assign pins_nxt.lamp  = lamp_nxt;
  assign pins_nxt.pulse = pulse_nxt;

endmodule
`default_nettype wire

@@ hw/rtl/three_phase_pattern_sequencer.sv @@
`default_nettype none
// Takes one beat per clock: a received command byte (command 0) or a 50 us tick
// (command 1), and returns one result beat per input beat in the cycle after it, with the
// phase, lamp and pulse pin levels after that beat plus the reply flags for a completed
// byte pair. All work for a beat is done combinationally in the command decoder and
// the tick sequencer and lands in the output register; the input is stalled only while
// that register holds a beat that the receiver is stalling, so the sustained rate is
// one beat per cycle. Configuration writes (index 0 burst_repeats, index 1
// pulse_half_ticks) take effect on the next tick that reads them.
module three_phase_pattern_sequencer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output wire logic                              in_stall,
  input  tpps_pkg::in_t                          in_data,
  output wire logic                              out_valid,
  input  wire logic                              out_stall,
  output tpps_pkg::out_t                         out_data,
  input  wire logic                              cfg_we,
  input  wire logic [tpps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tpps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tpps_pkg::*;

  cfg_t       cfg_r;
  cmd_state_t cmd_state;
  reply_t     reply;
  pins_t      pins_nxt;
  logic       out_valid_r;
  out_t       out_data_r;
  logic       in_acc;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.burst_repeats    <= BURST_REPEATS_RST;
      cfg_r.pulse_half_ticks <= PULSE_HALF_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BURST_REPEATS:    cfg_r.burst_repeats    <= cfg_data[7:0];
        CFG_PULSE_HALF_TICKS: cfg_r.pulse_half_ticks <= cfg_data[15:0];
        default:              ;
      endcase
    end
  end

  tpps_cmd u_cmd (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (in_acc && !in_data.command),
    .rx_byte   (in_data.rx_byte),
    .cmd_state (cmd_state),
    .reply     (reply)
  );

  tpps_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_en   (in_acc && in_data.command),
    .cmd_state (cmd_state),
    .cfg       (cfg_r),
    .pins_nxt  (pins_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r.phase_a        <= pins_nxt.phase[0];
      out_data_r.phase_b        <= pins_nxt.phase[1];
      out_data_r.phase_c        <= pins_nxt.phase[2];
      out_data_r.lamp_idle      <= pins_nxt.lamp[0];
      out_data_r.lamp_pulse     <= pins_nxt.lamp[1];
      out_data_r.lamp_phase     <= pins_nxt.lamp[2];
      out_data_r.pulse_out      <= pins_nxt.pulse;
      out_data_r.reply_valid    <= reply.valid;
      out_data_r.reply_is_error <= reply.is_error;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_acc_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_err_needs_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.reply_is_error) |-> out_data_r.reply_valid)
    else $error("error flag without reply");

  a_pulse_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.pulse_out) |-> out_data_r.lamp_pulse)
    else $error("pulse pin high outside pulse mode");

  a_some_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($countones({out_data_r.lamp_idle, out_data_r.lamp_pulse,
                                 out_data_r.lamp_phase}) != 0))
    else $error("no lamp lit");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tpps_pkg::*;

  localparam logic CMD_BYTE      = 1'b0;
  localparam logic CMD_TICK      = 1'b1;
  localparam int   LONG_HOLD     = 80;
  localparam int   SETTLE_CYCLES = 10;

  class sequencer_scoreboard;
    logic [7:0]            burst_limit;
    logic [15:0]           half_ticks;
    logic [7:0]            prefix;
    logic [7:0]            req_mode;
    logic [7:0]            delay;
    logic [7:0]            cycles_done;
    logic [1:0]            mode;
    logic [2:0]            phase;
    logic [2:0]            step;
    logic [2:0]            lamps;
    logic [WAIT_WIDTH-1:0] wait_left;
    logic                  pulse;
    out_t                  levels_due[$];
    int                    errors;
    int                    beats;
    int                    ticks;
    int                    replies;
    int                    error_replies;

    function new();
      burst_limit   = BURST_REPEATS_RST;
      half_ticks    = PULSE_HALF_TICKS_RST;
      prefix        = NO_PREFIX;
      req_mode      = CH_0;
      delay         = '0;
      cycles_done   = '0;
      mode          = MODE_IDLE;
      phase         = '0;
      step          = '0;
      lamps         = LAMP_IDLE;
      wait_left     = '0;
      pulse         = 1'b0;
      errors        = 0;
      beats         = 0;
      ticks         = 0;
      replies       = 0;
      error_replies = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_BURST_REPEATS: begin
          burst_limit = val[7:0];
        end
        CFG_PULSE_HALF_TICKS: begin
          half_ticks = val;
        end
        default: begin
        end
      endcase
    endfunction

    function logic [7:0] char_delay(logic [7:0] c);
      int idx;
      idx = -1;
      if (c >= CH_0 && c <= CH_9) begin
        idx = int'(c - CH_0);
      end else if (c >= CH_LA && c <= CH_LZ) begin
        idx = int'(LOWER_BASE_IDX) + int'(c - CH_LA);
      end else if (c >= CH_UB && c <= CH_UZ) begin
        idx = int'(UPPER_BASE_IDX) + int'(c - CH_UB);
      end
      if (idx < 0) begin
        return DELAY_FALLBACK;
      end
      return 8'(int'(DELAY_BASE) - 3 * idx);
    endfunction

    // zero becomes one tick, anything too long saturates
    function logic [WAIT_WIDTH-1:0] hold_len(logic [31:0] d);
      if (d == 0) begin
        return WAIT_WIDTH'(1);
      end
      if (d > WAIT_MAX) begin
        return WAIT_WIDTH'(WAIT_MAX);
      end
      return d[WAIT_WIDTH-1:0];
    endfunction

    function void take_step();
      logic [2:0] pin;
      pin = 3'b001 << (step % 3);
      if (step[0]) begin
        phase = phase | pin;
      end else begin
        phase = phase & ~pin;
      end
      wait_left = hold_len(32'(delay));
    endfunction

    function void latch();
      case (req_mode)
        CH_0: begin
          lamps = LAMP_IDLE;
          mode  = MODE_IDLE;
        end
        CH_1: begin
          lamps     = LAMP_PULSE;
          pulse     = 1'b1;
          wait_left = hold_len(32'(half_ticks));
          mode      = MODE_PULSE;
        end
        CH_2: begin
          lamps = LAMP_PHASE;
          if (burst_limit == 0) begin
            mode = MODE_IDLE;
          end else begin
            cycles_done = '0;
            step        = '0;
            take_step();
            mode = MODE_PHASE;
          end
        end
        default: begin
          lamps = LAMP_UNKNOWN;
          mode  = MODE_IDLE;
        end
      endcase
    endfunction

    function void tick();
      if (mode != MODE_PULSE && mode != MODE_PHASE) begin
        latch();
      end else if (wait_left > 1) begin
        wait_left = wait_left - WAIT_WIDTH'(1);
      end else if (mode == MODE_PULSE) begin
        if (pulse) begin
          pulse     = 1'b0;
          wait_left = hold_len(32'(half_ticks));
        end else begin
          latch();
        end
      end else begin
        step = step + 3'd1;
        if (step >= STEPS_PER_CYCLE) begin
          step        = '0;
          cycles_done = cycles_done + 8'd1;
        end
        // end of a six-step cycle with the burst complete
        if (step == 0 && cycles_done >= burst_limit) begin
          latch();
        end else begin
          take_step();
        end
      end
    endfunction

    function void predict_levels(in_t b);
      out_t lv;
      lv = '0;
      beats++;
      if (b.command == CMD_TICK) begin
        ticks++;
        tick();
      end else if (prefix == NO_PREFIX) begin
        prefix = b.rx_byte;
      end else begin
        lv.reply_valid = 1'b1;
        replies++;
        if (prefix == CH_T) begin
          delay = char_delay(b.rx_byte);
        end else if (prefix == CH_S) begin
          req_mode = b.rx_byte;
        end else begin
          lv.reply_is_error = 1'b1;
          error_replies++;
        end
        prefix = NO_PREFIX;
      end
      lv.phase_a    = phase[0];
      lv.phase_b    = phase[1];
      lv.phase_c    = phase[2];
      lv.lamp_idle  = lamps[0];
      lv.lamp_pulse = lamps[1];
      lv.lamp_phase = lamps[2];
      lv.pulse_out  = pulse;
      levels_due.push_back(lv);
    endfunction

    function void compare_pin(string name, logic want, logic got);
      if (want !== got) begin
        $error("%s: expected %0b, got %0b", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (levels_due.size() == 0) begin
        $error("result beat with nothing expected: %b", got);
        errors++;
        return;
      end
      want = levels_due.pop_front();
      compare_pin("phase_a", want.phase_a, got.phase_a);
      compare_pin("phase_b", want.phase_b, got.phase_b);
      compare_pin("phase_c", want.phase_c, got.phase_c);
      compare_pin("lamp_idle", want.lamp_idle, got.lamp_idle);
      compare_pin("lamp_pulse", want.lamp_pulse, got.lamp_pulse);
      compare_pin("lamp_phase", want.lamp_phase, got.lamp_phase);
      compare_pin("pulse_out", want.pulse_out, got.pulse_out);
      compare_pin("reply_valid", want.reply_valid, got.reply_valid);
      compare_pin("reply_is_error", want.reply_is_error, got.reply_is_error);
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bit snd_idling   = 1'b1;
  bit rcv_idling   = 1'b1;
  bit hold_request = 1'b0;
  int beats_sent   = 0;
  int reg_writes   = 0;

  sequencer_scoreboard sb = new();

  three_phase_pattern_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.predict_levels(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
      end
    end
  end

  // receiver: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_stall <= rcv_idling && ($urandom_range(99) < 9);
    end
  end

  task automatic send_beat(logic cmd, logic [7:0] data);
    if (snd_idling && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, rx_byte: data};
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    beats_sent++;
  endtask

  task automatic send_pair(logic [7:0] pfx, logic [7:0] arg);
    send_beat(CMD_BYTE, pfx);
    send_beat(CMD_BYTE, arg);
  endtask

  task automatic send_ticks(int n);
    repeat (n) begin
      send_beat(CMD_TICK, 8'($urandom_range(255)));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.levels_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [7:0] bursts, logic [15:0] half, int count, bit idling,
                           bit squeeze);
    int         start;
    int         k;
    logic [7:0] arg;
    // upper bits of the burst write are don't-care
    write_reg(CFG_BURST_REPEATS, {8'($urandom_range(255)), bursts});
    write_reg(CFG_PULSE_HALF_TICKS, half);
    snd_idling = idling;
    rcv_idling = idling;
    if (squeeze) begin
      hold_request = 1'b1;
    end
    start = beats_sent;
    while (beats_sent - start < count) begin
      k = $urandom_range(99);
      if (k < 45) begin
        send_ticks($urandom_range(1, 16));
      end else if (k < 65) begin
        case ($urandom_range(9))
          0, 1, 2: arg = CH_0;
          3, 4, 5: arg = CH_1;
          6, 7, 8: arg = CH_2;
          default: arg = 8'($urandom_range(255));
        endcase
        send_pair(CH_S, arg);
      end else if (k < 85) begin
        // mostly short step delays so bursts finish
        if ($urandom_range(99) < 85) begin
          arg = 8'($urandom_range(int'(CH_UZ), int'(CH_UZ) - 8));
        end else begin
          arg = 8'($urandom_range(255));
        end
        send_pair(CH_T, arg);
      end else if (k < 92) begin
        send_pair(8'($urandom_range(255)), 8'($urandom_range(255)));
      end else begin
        send_beat(CMD_BYTE, 8'($urandom_range(255)));
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_BURST_REPEATS, 16'd1);
    write_reg(CFG_PULSE_HALF_TICKS, 16'd0);
    send_ticks(1);
    send_beat(CMD_BYTE, NO_PREFIX);
    // unknown prefix gets an error reply
    send_pair(8'h58, 8'hff);
    send_pair(CH_S, CH_2);
    send_ticks(7);
    send_pair(CH_S, CH_1);
    send_ticks(3);
    send_pair(CH_S, 8'h80);
    send_ticks(3);
    send_pair(CH_T, CH_0);
    send_pair(CH_T, CH_LA);
    send_pair(CH_T, CH_UZ);
    send_pair(CH_T, 8'h7f);
    send_pair(CH_S, CH_0);
    send_ticks(2);
    wait_drained();

    run_phase(8'd1, 16'd3, 160, 1'b1, 1'b0);
    run_phase(8'd0, 16'd1, 100, 1'b0, 1'b0);
    run_phase(8'd2, 16'd0, 160, 1'b1, 1'b1);
    run_phase(8'd4, 16'd9, 160, 1'b1, 1'b0);
    run_phase(8'd255, 16'hffff, 120, 1'b1, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.levels_due.size() != 0) begin
      $error("%0d result beats never arrived", sb.levels_due.size());
      sb.errors++;
    end
    $display("covered %0d beats: %0d ticks, %0d byte pairs answered (%0d with error reply)",
             sb.beats, sb.ticks, sb.replies, sb.error_replies);
    $display("across %0d register writes, including zero and full-scale settings", reg_writes);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tpps_pkg.sv
hw/rtl/tpps_cmd.sv
hw/rtl/tpps_seq.sv
hw/rtl/three_phase_pattern_sequencer.sv
verif/tb_top.sv
